### hdl/mlco_pkg.sv
package mlco_pkg;

    localparam logic [1:0] CMD_APPEND   = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;
    localparam logic [1:0] CMD_PROGRESS = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_BAD_OWNER = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_NOTHING   = 3'd5;
    localparam logic [2:0] ST_IGNORED   = 3'd6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LANES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWNERS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSUMERS = 2'd2;

    localparam logic [3:0] LANES_RST     = 4'd8;
    localparam logic [4:0] OWNERS_RST    = 5'd16;
    localparam logic [2:0] CONSUMERS_RST = 3'd4;

    localparam logic [1:0] LVL_CALC   = 2'd1;
    localparam logic [1:0] LVL_SUBMIT = 2'd2;

    localparam logic [10:0] LAG_MAX = 11'h7FF;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  lane;
        logic [1:0]  consumer;
        logic [3:0]  owner;
        logic        to_all;
        logic        broadcast_kind;
        logic [63:0] payload;
        logic [1:0]  progress_level;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  out_lane;
        logic [63:0] out_sequence;
        logic [3:0]  out_owner;
        logic        out_broadcast_kind;
        logic [63:0] out_payload;
        logic [13:0] skipped;
        logic [10:0] max_lag;
        logic        all_consumed;
        logic        all_calculated;
        logic        all_submitted;
    } t_out;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic err_load;
        logic min_init;
        logic min_step;
        logic min_last;
        logic app_finish;
        logic rd_load_poll;
        logic rd_mod;
        logic cur_get;
        logic lane_test;
        logic rec_check;
        logic q_init;
        logic q_step;
        logic q_eval;
        logic q_finish;
        logic prog_write;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic       err;
        logic [1:0] cmd;
        logic       clear_last;
        logic       scan_last;
        logic       q_last;
        logic       mod_done;
        logic       has_rec;
        logic       lanes_last;
        logic       hit;
        logic       out_free;
    } t_sts;

endpackage

### hdl/mlco_controller.sv
module mlco_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mlco_pkg::t_sts   i_sts,
    output mlco_pkg::t_ctl   o_ctl
);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_CHECK  = 17'h00004,
        S_MIN    = 17'h00008,
        S_MINL   = 17'h00010,
        S_FULL   = 17'h00020,
        S_RLOAD  = 17'h00040,
        S_RMOD   = 17'h00080,
        S_LCUR   = 17'h00100,
        S_LGET   = 17'h00200,
        S_LTEST  = 17'h00400,
        S_LREC   = 17'h00800,
        S_QSCAN  = 17'h01000,
        S_QLAST  = 17'h02000,
        S_QEND   = 17'h04000,
        S_PWRITE = 17'h08000,
        S_DONE   = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    o_ctl.err_load = 1'b1;
                    n_state = S_DONE;
                end else begin
                    case (i_sts.cmd)
                        mlco_pkg::CMD_APPEND: begin
                            o_ctl.min_init = 1'b1;
                            n_state = S_MIN;
                        end
                        mlco_pkg::CMD_READ: begin
                            n_state = S_RLOAD;
                        end
                        mlco_pkg::CMD_QUERY: begin
                            o_ctl.q_init = 1'b1;
                            n_state = S_QSCAN;
                        end
                        default: begin
                            n_state = S_PWRITE;
                        end
                    endcase
                end
            end
            S_MIN: begin
                o_ctl.min_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_MINL;
                end
            end
            S_MINL: begin
                o_ctl.min_last = 1'b1;
                n_state = S_FULL;
            end
            S_FULL: begin
                o_ctl.app_finish = 1'b1;
                n_state = S_DONE;
            end
            S_RLOAD: begin
                o_ctl.rd_load_poll = 1'b1;
                n_state = S_RMOD;
            end
            S_RMOD: begin
                if (i_sts.mod_done) begin
                    n_state = S_LCUR;
                end else begin
                    o_ctl.rd_mod = 1'b1;
                end
            end
            S_LCUR: begin
                n_state = S_LGET;
            end
            S_LGET: begin
                o_ctl.cur_get = 1'b1;
                n_state = S_LTEST;
            end
            S_LTEST: begin
                o_ctl.lane_test = 1'b1;
                if (i_sts.has_rec) begin
                    n_state = S_LREC;
                end else if (i_sts.lanes_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LCUR;
                end
            end
            S_LREC: begin
                o_ctl.rec_check = 1'b1;
                n_state = i_sts.hit ? S_DONE : S_LTEST;
            end
            S_QSCAN: begin
                o_ctl.q_step = 1'b1;
                if (i_sts.q_last) begin
                    n_state = S_QLAST;
                end
            end
            S_QLAST: begin
                o_ctl.q_eval = 1'b1;
                n_state = S_QEND;
            end
            S_QEND: begin
                o_ctl.q_finish = 1'b1;
                n_state = S_DONE;
            end
            S_PWRITE: begin
                o_ctl.prog_write = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/mlco_datapath.sv
module mlco_datapath #(
    parameter int LANES        = 8,
    parameter int OWNERS       = 16,
    parameter int CONSUMERS    = 4,
    parameter int DEPTH        = 1024,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mlco_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mlco_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  mlco_pkg::t_in                      i_in_data,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output mlco_pkg::t_out                     o_out_data,
    input  mlco_pkg::t_ctl                     i_ctl,
    output mlco_pkg::t_sts                     o_sts
);

    localparam int PAIRS   = CONSUMERS * OWNERS;
    localparam int CURSORS = PAIRS * LANES;
    localparam int SLOTS   = LANES * DEPTH;
    localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int OW  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int CW  = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
    localparam int PW  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int XW  = (CURSORS > 1) ? $clog2(CURSORS) : 1;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW  = $clog2(DEPTH);
    localparam int NLW = $clog2(LANES + 1);
    localparam int NOW = $clog2(OWNERS + 1);
    localparam int NCW = $clog2(CONSUMERS + 1);

    // configuration and control state
    logic [3:0]  r_cfg_lanes;
    logic [4:0]  r_cfg_owners;
    logic [2:0]  r_cfg_consumers;
    logic [63:0] r_head [LANES];
    logic [XW-1:0] r_clr;
    logic        r_out_v;
    mlco_pkg::t_out r_out;

    // working registers
    mlco_pkg::t_in  r_item;
    mlco_pkg::t_out r_res;
    mlco_pkg::t_out n_res;
    logic [CW-1:0]  r_c;
    logic [OW-1:0]  r_o;
    logic [LW-1:0]  r_l;
    logic [LW-1:0]  r_ld;
    logic           r_pend;
    logic           r_qv;
    logic [63:0]    r_min;
    logic [63:0]    r_max;
    logic           r_cd;
    logic           r_ca;
    logic           r_su;
    logic [LW-1:0]  r_lane;
    logic [NLW-1:0] r_n;
    logic [63:0]    r_next;
    logic [13:0]    r_skip;

    // memories
    logic [PAYLOAD_BITS-1:0] r_pay_mem [SLOTS];
    logic [5:0]              r_tag_mem [SLOTS];
    logic [63:0]             r_cur_mem [CURSORS];
    logic [63:0]             r_del_mem [PAIRS];
    logic [63:0]             r_calc_mem [PAIRS];
    logic [63:0]             r_sub_mem [PAIRS];
    logic [LW-1:0]           r_poll_mem [PAIRS];
    logic [PAYLOAD_BITS-1:0] r_pay_q;
    logic [5:0]              r_tag_q;
    logic [63:0]             r_cur_q;
    logic [63:0]             r_del_q;
    logic [63:0]             r_calc_q;
    logic [63:0]             r_sub_q;
    logic [LW-1:0]           r_poll_q;

    logic [NLW-1:0] nl;
    logic [NOW-1:0] no;
    logic [NCW-1:0] nc;
    logic [LW-1:0]  it_lane;
    logic [OW-1:0]  it_own;
    logic [CW-1:0]  it_cons;
    logic [LW-1:0]  head_addr;
    logic [63:0]    head_rd;
    logic [2:0]     err_code;
    logic           lane_bad;
    logic           cons_bad;
    logic           own_bad;
    logic [63:0]    seq;
    logic           full;
    logic [63:0]    done_q;
    logic           q_gt;
    logic [63:0]    q_diff;
    logic           hit;
    logic [LW-1:0]  lane_nx;
    logic           has_rec;
    logic           lanes_last;
    logic           o_last;
    logic           c_last;
    logic           l_last;
    logic           min_cmp;
    logic           q_cmp;
    logic           clr_pair;
    logic           rec_we;
    logic [SW-1:0]  app_slot;
    logic [SW-1:0]  rec_raddr;
    logic [5:0]     app_tag;
    logic [XW-1:0]  cur_raddr;
    logic [XW-1:0]  cur_waddr;
    logic [63:0]    cur_wdata;
    logic           cur_we;
    logic [PW-1:0]  pair_raddr;
    logic [PW-1:0]  pair_waddr;
    logic           del_we;
    logic           calc_we;
    logic           sub_we;
    logic           poll_we;
    logic [63:0]    del_wd;
    logic [63:0]    mark_wd;
    logic [LW-1:0]  poll_wd;

    function automatic logic [SW-1:0] f_slot(input logic [LW-1:0] l, input logic [63:0] s);
        return SW'(32'(l) * DEPTH + 32'(DW'(s[DW-1:0] - DW'(1))));
    endfunction

    function automatic logic [XW-1:0] f_cur(input logic [CW-1:0] c, input logic [OW-1:0] o,
                                            input logic [LW-1:0] l);
        return XW'((32'(c) * OWNERS + 32'(o)) * LANES + 32'(l));
    endfunction

    function automatic logic [PW-1:0] f_pair(input logic [CW-1:0] c, input logic [OW-1:0] o);
        return PW'(32'(c) * OWNERS + 32'(o));
    endfunction

    always_comb begin
        if (r_cfg_lanes == 4'd0) begin
            nl = NLW'(1);
        end else if (32'(r_cfg_lanes) > LANES) begin
            nl = NLW'(LANES);
        end else begin
            nl = NLW'(r_cfg_lanes);
        end
        if (r_cfg_owners == 5'd0) begin
            no = NOW'(1);
        end else if (32'(r_cfg_owners) > OWNERS) begin
            no = NOW'(OWNERS);
        end else begin
            no = NOW'(r_cfg_owners);
        end
        if (r_cfg_consumers == 3'd0) begin
            nc = NCW'(1);
        end else if (32'(r_cfg_consumers) > CONSUMERS) begin
            nc = NCW'(CONSUMERS);
        end else begin
            nc = NCW'(r_cfg_consumers);
        end
    end

    assign it_lane = LW'(r_item.lane);
    assign it_own  = OW'(r_item.owner);
    assign it_cons = CW'(r_item.consumer);

    always_comb begin
        case (r_item.command)
            mlco_pkg::CMD_APPEND: head_addr = it_lane;
            mlco_pkg::CMD_QUERY:  head_addr = r_ld;
            default:              head_addr = r_lane;
        endcase
    end
    assign head_rd = r_head[head_addr];

    assign lane_bad = 32'(r_item.lane) >= 32'(nl);
    assign cons_bad = 32'(r_item.consumer) >= 32'(nc);
    assign own_bad  = 32'(r_item.owner) >= 32'(no);

    always_comb begin
        err_code = mlco_pkg::ST_OK;
        case (r_item.command)
            mlco_pkg::CMD_APPEND: begin
                if (lane_bad) begin
                    err_code = mlco_pkg::ST_BAD_INDEX;
                end else if ((r_item.to_all != r_item.broadcast_kind)
                             || (!r_item.to_all && own_bad)) begin
                    err_code = mlco_pkg::ST_BAD_OWNER;
                end else if (head_rd == '1) begin
                    err_code = mlco_pkg::ST_EXHAUSTED;
                end
            end
            mlco_pkg::CMD_READ: begin
                if (cons_bad) begin
                    err_code = mlco_pkg::ST_BAD_INDEX;
                end else if (own_bad) begin
                    err_code = mlco_pkg::ST_BAD_OWNER;
                end
            end
            mlco_pkg::CMD_QUERY: begin
                if (cons_bad) begin
                    err_code = mlco_pkg::ST_BAD_INDEX;
                end
            end
            default: begin
                if (cons_bad) begin
                    err_code = mlco_pkg::ST_BAD_INDEX;
                end else if (own_bad) begin
                    err_code = mlco_pkg::ST_BAD_OWNER;
                end else if ((r_item.progress_level != mlco_pkg::LVL_CALC)
                             && (r_item.progress_level != mlco_pkg::LVL_SUBMIT)) begin
                    err_code = mlco_pkg::ST_IGNORED;
                end
            end
        endcase
    end

    assign seq    = head_rd + 64'd1;
    assign full   = (seq - r_min) >= 64'(DEPTH);
    assign done_q = (r_cur_q == 64'd0) ? 64'd0 : r_cur_q - 64'd1;
    assign q_gt   = head_rd > done_q;
    assign q_diff = head_rd - done_q;
    assign hit    = r_tag_q[4] | (r_tag_q[3:0] == r_item.owner);
    assign lane_nx = (32'(r_lane) + 32'd1 >= 32'(nl)) ? '0 : LW'(32'(r_lane) + 32'd1);
    assign has_rec = r_next <= head_rd;
    assign lanes_last = 32'(r_n) + 32'd1 >= 32'(nl);
    assign o_last = 32'(r_o) + 32'd1 >= 32'(no);
    assign c_last = 32'(r_c) + 32'd1 >= 32'(nc);
    assign l_last = 32'(r_l) + 32'd1 >= 32'(nl);
    assign min_cmp = (i_ctl.min_step | i_ctl.min_last) & r_pend;
    assign q_cmp   = (i_ctl.q_step | i_ctl.q_eval) & r_qv;
    assign clr_pair = i_ctl.clear_step & (32'(r_clr) < PAIRS);

    assign rec_we    = i_ctl.app_finish & !full;
    assign app_slot  = f_slot(it_lane, seq);
    assign rec_raddr = f_slot(r_lane, r_next);
    assign app_tag   = {r_item.broadcast_kind, r_item.to_all, r_item.owner};

    always_comb begin
        case (r_item.command)
            mlco_pkg::CMD_APPEND: cur_raddr = f_cur(r_c, r_o, it_lane);
            mlco_pkg::CMD_QUERY:  cur_raddr = f_cur(it_cons, r_o, r_l);
            default:              cur_raddr = f_cur(it_cons, it_own, r_lane);
        endcase
    end

    assign cur_we    = i_ctl.clear_step | (i_ctl.lane_test & !has_rec)
                       | (i_ctl.rec_check & hit);
    assign cur_waddr = i_ctl.clear_step ? r_clr : f_cur(it_cons, it_own, r_lane);
    always_comb begin
        if (i_ctl.clear_step) begin
            cur_wdata = 64'd1;
        end else if (i_ctl.rec_check) begin
            cur_wdata = r_next + 64'd1;
        end else begin
            cur_wdata = r_next;
        end
    end

    assign pair_raddr = (r_item.command == mlco_pkg::CMD_QUERY) ? f_pair(it_cons, r_o)
                                                                  : f_pair(it_cons, it_own);
    assign pair_waddr = i_ctl.clear_step ? r_clr[PW-1:0] : f_pair(it_cons, it_own);
    assign del_we  = clr_pair | (i_ctl.rec_check & hit);
    assign poll_we = del_we;
    assign calc_we = clr_pair | i_ctl.prog_write;
    assign sub_we  = clr_pair
                     | (i_ctl.prog_write & (r_item.progress_level == mlco_pkg::LVL_SUBMIT));
    assign del_wd  = i_ctl.clear_step ? 64'd0 : r_del_q + 64'd1;
    assign mark_wd = i_ctl.clear_step ? 64'd0 : r_del_q;
    assign poll_wd = i_ctl.clear_step ? '0 : lane_nx;

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_pay_mem[app_slot] <= r_item.payload[PAYLOAD_BITS-1:0];
            r_tag_mem[app_slot] <= app_tag;
        end
        r_pay_q <= r_pay_mem[rec_raddr];
        r_tag_q <= r_tag_mem[rec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            r_cur_mem[cur_waddr] <= cur_wdata;
        end
        r_cur_q <= r_cur_mem[cur_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (del_we) begin
            r_del_mem[pair_waddr] <= del_wd;
        end
        if (calc_we) begin
            r_calc_mem[pair_waddr] <= mark_wd;
        end
        if (sub_we) begin
            r_sub_mem[pair_waddr] <= mark_wd;
        end
        if (poll_we) begin
            r_poll_mem[pair_waddr] <= poll_wd;
        end
        r_del_q  <= r_del_mem[pair_raddr];
        r_calc_q <= r_calc_mem[pair_raddr];
        r_sub_q  <= r_sub_mem[pair_raddr];
        r_poll_q <= r_poll_mem[pair_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lanes     <= mlco_pkg::LANES_RST;
            r_cfg_owners    <= mlco_pkg::OWNERS_RST;
            r_cfg_consumers <= mlco_pkg::CONSUMERS_RST;
            for (int i = 0; i < LANES; i++) begin
                r_head[i] <= 64'd0;
            end
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mlco_pkg::CFG_LANES:     r_cfg_lanes     <= i_cfg_data[3:0];
                    mlco_pkg::CFG_OWNERS:    r_cfg_owners    <= i_cfg_data[4:0];
                    mlco_pkg::CFG_CONSUMERS: r_cfg_consumers <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_ctl.clear_step) begin
                r_clr <= XW'(32'(r_clr) + 32'd1);
            end
            if (rec_we) begin
                r_head[it_lane] <= seq;
            end
            if (i_ctl.out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        n_res = r_res;
        if (i_ctl.err_load) begin
            n_res        = '0;
            n_res.status = err_code;
        end
        if (i_ctl.app_finish) begin
            n_res = '0;
            if (full) begin
                n_res.status = mlco_pkg::ST_FULL;
            end else begin
                n_res.status       = mlco_pkg::ST_OK;
                n_res.out_lane     = r_item.lane;
                n_res.out_sequence = seq;
            end
        end
        if (i_ctl.lane_test && !has_rec && lanes_last) begin
            n_res         = '0;
            n_res.status  = mlco_pkg::ST_NOTHING;
            n_res.skipped = r_skip;
        end
        if (i_ctl.rec_check && hit) begin
            n_res                    = '0;
            n_res.status             = mlco_pkg::ST_OK;
            n_res.out_lane           = 3'(r_lane);
            n_res.out_sequence       = r_next;
            n_res.out_owner          = r_item.owner;
            n_res.out_broadcast_kind = r_tag_q[5];
            n_res.out_payload        = 64'(r_pay_q);
            n_res.skipped            = r_skip;
        end
        if (i_ctl.q_finish) begin
            n_res                = '0;
            n_res.status         = mlco_pkg::ST_OK;
            n_res.max_lag        = (r_max > 64'(mlco_pkg::LAG_MAX)) ? mlco_pkg::LAG_MAX
                                                                    : r_max[10:0];
            n_res.all_consumed   = r_cd;
            n_res.all_calculated = r_cd & r_ca;
            n_res.all_submitted  = r_cd & r_ca & r_su;
        end
        if (i_ctl.prog_write) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item <= i_in_data;
        end
        if (i_ctl.out_load) begin
            r_out <= r_res;
        end
        r_res <= n_res;
        if (i_ctl.min_init) begin
            r_c    <= '0;
            r_o    <= '0;
            r_pend <= 1'b0;
            r_min  <= '1;
        end
        if (i_ctl.min_step) begin
            r_pend <= 1'b1;
            if (o_last) begin
                r_o <= '0;
                r_c <= CW'(32'(r_c) + 32'd1);
            end else begin
                r_o <= OW'(32'(r_o) + 32'd1);
            end
        end
        if (min_cmp && (r_cur_q < r_min)) begin
            r_min <= r_cur_q;
        end
        if (i_ctl.q_init) begin
            r_o   <= '0;
            r_l   <= '0;
            r_qv  <= 1'b0;
            r_max <= 64'd0;
            r_cd  <= 1'b1;
            r_ca  <= 1'b1;
            r_su  <= 1'b1;
        end
        if (i_ctl.q_step) begin
            r_qv <= 1'b1;
            r_ld <= r_l;
            if (l_last) begin
                r_l <= '0;
                r_o <= OW'(32'(r_o) + 32'd1);
            end else begin
                r_l <= LW'(32'(r_l) + 32'd1);
            end
        end
        if (q_cmp) begin
            if (q_gt) begin
                r_cd <= 1'b0;
                if (q_diff > r_max) begin
                    r_max <= q_diff;
                end
            end
            if (r_calc_q != r_del_q) begin
                r_ca <= 1'b0;
            end
            if (r_sub_q != r_del_q) begin
                r_su <= 1'b0;
            end
        end
        if (i_ctl.rd_load_poll) begin
            r_lane <= r_poll_q;
            r_n    <= '0;
            r_skip <= '0;
        end
        if (i_ctl.rd_mod) begin
            r_lane <= LW'(32'(r_lane) - 32'(nl));
        end
        if (i_ctl.cur_get) begin
            r_next <= r_cur_q;
        end
        if (i_ctl.lane_test && !has_rec) begin
            r_n    <= NLW'(32'(r_n) + 32'd1);
            r_lane <= lane_nx;
        end
        if (i_ctl.rec_check) begin
            r_next <= r_next + 64'd1;
            if (!hit) begin
                r_skip <= r_skip + 14'd1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts            = '0;
        o_sts.err        = (err_code != mlco_pkg::ST_OK);
        o_sts.cmd        = r_item.command;
        o_sts.clear_last = (32'(r_clr) == CURSORS - 1);
        o_sts.scan_last  = o_last & c_last;
        o_sts.q_last     = o_last & l_last;
        o_sts.mod_done   = 32'(r_lane) < 32'(nl);
        o_sts.has_rec    = has_rec;
        o_sts.lanes_last = lanes_last;
        o_sts.hit        = hit;
        o_sts.out_free   = !r_out_v | !i_out_stall;
    end

endmodule

### hdl/multi_lane_cursor_outbox.sv
// Reset: the cursor and per-pair memories are swept (LANES*OWNERS*CONSUMERS cursors, 512 by
// default) with the input stalled; config writes are taken throughout.
// One item at a time: the input stays stalled from accept until its result is loaded.
// An append walks every consumer's and owner's cursor on its lane, a query every owner and lane
// of its consumer, one entry a cycle; a read reduces a stale poll start by the lane count, then
// polls lanes from it, passing over other owners' records. A waiting result delays the next load.
module multi_lane_cursor_outbox #(
    parameter int LANES        = 8,
    parameter int OWNERS       = 16,
    parameter int CONSUMERS    = 4,
    parameter int DEPTH        = 1024,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlco_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mlco_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mlco_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mlco_pkg::t_out                  o_out_data
);

    mlco_pkg::t_ctl ctl;
    mlco_pkg::t_sts sts;

    mlco_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    mlco_datapath #(
        .LANES        (LANES),
        .OWNERS       (OWNERS),
        .CONSUMERS    (CONSUMERS),
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

endmodule

### tb/tb_multi_lane_cursor_outbox.sv
`timescale 1ns / 1ps

module tb_multi_lane_cursor_outbox;
    import mlco_pkg::*;

    localparam int N_LANES  = 8;
    localparam int N_OWNERS = 16;
    localparam int N_CONS   = 4;
    localparam int RING     = 1024;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in                   in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;

    multi_lane_cursor_outbox uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the outbox state
    logic [63:0] rec_payload [N_LANES*RING];
    logic [5:0]  rec_tag     [N_LANES*RING];
    logic [63:0] head_seq    [N_LANES];
    logic [63:0] next_seq    [N_CONS*N_OWNERS*N_LANES];
    int          poll_lane   [N_CONS*N_OWNERS];
    logic [63:0] deliv_cnt   [N_CONS*N_OWNERS];
    logic [63:0] calc_mark   [N_CONS*N_OWNERS];
    logic [63:0] subm_mark   [N_CONS*N_OWNERS];
    logic [3:0]  lanes_reg  = LANES_RST;
    logic [4:0]  owners_reg = OWNERS_RST;
    logic [2:0]  cons_reg   = CONSUMERS_RST;

    t_out pending_results [$];
    int   errors = 0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_full = 0;
    bit   no_idle = 0;
    int   hold_left = 0;
    int   rx_wait = 0;

    function automatic int eff(int v, int top);
        if (v == 0) return 1;
        return v > top ? top : v;
    endfunction

    function automatic int n_lanes();
        return eff(lanes_reg, N_LANES);
    endfunction

    function automatic int n_owners();
        return eff(owners_reg, N_OWNERS);
    endfunction

    function automatic int n_cons();
        return eff(cons_reg, N_CONS);
    endfunction

    function automatic int cur_idx(int c, int o, int l);
        return (c * N_OWNERS + o) * N_LANES + l;
    endfunction

    function automatic int slot_idx(int l, logic [63:0] seq);
        logic [63:0] s;
        s = seq - 64'd1;
        return l * RING + int'(s[9:0]);
    endfunction

    function automatic t_out outbox_step(t_in it);
        t_out        r;
        int          nl, no, nc, pair, l, ci, s;
        logic [63:0] seq, lo, nxt, hd, done, lag, maxlag, skip;
        logic [5:0]  tag;
        bit          cd, ca, su;
        r = '0;
        nl = n_lanes();
        no = n_owners();
        nc = n_cons();
        pair = it.consumer * N_OWNERS + it.owner;
        case (it.command)
            CMD_APPEND: begin
                if (it.lane >= nl) begin
                    r.status = ST_BAD_INDEX;
                end else if (it.to_all != it.broadcast_kind ||
                             (!it.to_all && it.owner >= no)) begin
                    r.status = ST_BAD_OWNER;
                end else if (head_seq[it.lane] == '1) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    seq = head_seq[it.lane] + 64'd1;
                    lo = '1;
                    for (int c = 0; c < nc; c++)
                        for (int o = 0; o < no; o++)
                            if (next_seq[cur_idx(c, o, it.lane)] < lo)
                                lo = next_seq[cur_idx(c, o, it.lane)];
                    if (seq - lo >= RING) begin
                        r.status = ST_FULL;
                    end else begin
                        s = slot_idx(it.lane, seq);
                        rec_payload[s] = it.payload;
                        rec_tag[s] = {it.broadcast_kind, it.to_all, it.owner};
                        head_seq[it.lane] = seq;
                        r.out_lane = it.lane;
                        r.out_sequence = seq;
                    end
                end
            end
            CMD_READ: begin
                if (it.consumer >= nc) begin
                    r.status = ST_BAD_INDEX;
                end else if (it.owner >= no) begin
                    r.status = ST_BAD_OWNER;
                end else begin
                    skip = 0;
                    for (int n = 0; n < nl; n++) begin
                        l = (poll_lane[pair] + n) % nl;
                        ci = cur_idx(it.consumer, it.owner, l);
                        hd = head_seq[l];
                        while (next_seq[ci] <= hd) begin
                            seq = next_seq[ci];
                            s = slot_idx(l, seq);
                            tag = rec_tag[s];
                            next_seq[ci] = seq + 64'd1;
                            if (tag[4] || tag[3:0] == it.owner) begin
                                deliv_cnt[pair] = deliv_cnt[pair] + 64'd1;
                                poll_lane[pair] = (l + 1) % nl;
                                r.out_lane = 3'(l);
                                r.out_sequence = seq;
                                r.out_owner = it.owner;
                                r.out_broadcast_kind = tag[5];
                                r.out_payload = rec_payload[s];
                                r.skipped = skip[13:0];
                                return r;
                            end
                            skip++;
                        end
                    end
                    r.status = ST_NOTHING;
                    r.skipped = skip[13:0];
                end
            end
            CMD_QUERY: begin
                if (it.consumer >= nc) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    maxlag = 0;
                    cd = 1'b1;
                    ca = 1'b1;
                    su = 1'b1;
                    for (int o = 0; o < no; o++) begin
                        lag = 0;
                        pair = it.consumer * N_OWNERS + o;
                        for (int k = 0; k < nl; k++) begin
                            hd = head_seq[k];
                            nxt = next_seq[cur_idx(it.consumer, o, k)];
                            done = (nxt == 0) ? 64'd0 : nxt - 64'd1;
                            if (hd > done && hd - done > lag) lag = hd - done;
                        end
                        if (lag > maxlag) maxlag = lag;
                        if (lag != 0) cd = 1'b0;
                        if (calc_mark[pair] != deliv_cnt[pair]) ca = 1'b0;
                        if (subm_mark[pair] != deliv_cnt[pair]) su = 1'b0;
                    end
                    ca = ca && cd;
                    su = su && ca;
                    r.max_lag = (maxlag > LAG_MAX) ? LAG_MAX : maxlag[10:0];
                    r.all_consumed = cd;
                    r.all_calculated = ca;
                    r.all_submitted = su;
                end
            end
            default: begin
                if (it.consumer >= nc) begin
                    r.status = ST_BAD_INDEX;
                end else if (it.owner >= no) begin
                    r.status = ST_BAD_OWNER;
                end else if (it.progress_level != LVL_CALC &&
                             it.progress_level != LVL_SUBMIT) begin
                    r.status = ST_IGNORED;
                end else begin
                    calc_mark[pair] = deliv_cnt[pair];
                    if (it.progress_level == LVL_SUBMIT)
                        subm_mark[pair] = deliv_cnt[pair];
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input t_in it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(outbox_step(it));
        if (it.command == CMD_APPEND && pending_results[$].status == ST_FULL) n_full++;
        n_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LANES:  lanes_reg = val[3:0];
            CFG_OWNERS: owners_reg = val[4:0];
            default:    cons_reg = val[2:0];
        endcase
    endtask

    task automatic set_regs(input int l, input int o, input int c);
        drain();
        write_reg(CFG_LANES, l);
        write_reg(CFG_OWNERS, o);
        write_reg(CFG_CONSUMERS, c);
    endtask

    function automatic t_in mk(logic [1:0] cmd, int lane, int cons, int own,
                               bit ta, bit bk, logic [63:0] pl, int lvl);
        t_in it;
        it.command = cmd;
        it.lane = lane[2:0];
        it.consumer = cons[1:0];
        it.owner = own[3:0];
        it.to_all = ta;
        it.broadcast_kind = bk;
        it.payload = pl;
        it.progress_level = lvl[1:0];
        return it;
    endfunction

    function automatic t_in rand_item();
        t_in it;
        int  pick;
        pick = $urandom_range(0, 99);
        it.command = pick < 40 ? CMD_APPEND : pick < 75 ? CMD_READ :
                     pick < 85 ? CMD_QUERY : CMD_PROGRESS;
        it.lane = 3'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                : $urandom_range(0, n_lanes() - 1));
        it.owner = 4'($urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                                                 : $urandom_range(0, n_owners() - 1));
        it.consumer = 2'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3)
                                                    : $urandom_range(0, n_cons() - 1));
        it.to_all = $urandom_range(0, 4) == 0;
        it.broadcast_kind = ($urandom_range(0, 15) == 0) ? !it.to_all : it.to_all;
        it.payload = {$urandom, $urandom};
        it.progress_level = 2'($urandom_range(0, 3));
        return it;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (out_valid && !out_stall) begin
            rx_wait = no_idle ? 0 : $urandom_range(0, 6);
            if (pending_results.size() == 0) begin
                $error("result with no transfer pending: %h", out_data);
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, out_data.status);
                check_field("out_lane", e.out_lane, out_data.out_lane);
                check_field("out_sequence", e.out_sequence, out_data.out_sequence);
                check_field("out_owner", e.out_owner, out_data.out_owner);
                check_field("out_broadcast_kind", e.out_broadcast_kind,
                            out_data.out_broadcast_kind);
                check_field("out_payload", e.out_payload, out_data.out_payload);
                check_field("skipped", e.skipped, out_data.skipped);
                check_field("max_lag", e.max_lag, out_data.max_lag);
                check_field("all_consumed", e.all_consumed, out_data.all_consumed);
                check_field("all_calculated", e.all_calculated, out_data.all_calculated);
                check_field("all_submitted", e.all_submitted, out_data.all_submitted);
                n_checked++;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic test_basic_ops();
        send_item(mk(CMD_APPEND, 0, 0, 3, 0, 0, 64'd0, 0));
        send_item(mk(CMD_APPEND, 0, 0, 5, 1, 1, '1, 0));
        send_item(mk(CMD_APPEND, 7, 0, 15, 0, 0, 64'hA5A5_5A5A_F0F0_0F0F, 3));
        send_item(mk(CMD_APPEND, 1, 0, 2, 1, 0, 64'd1, 0));
        send_item(mk(CMD_APPEND, 1, 0, 2, 0, 1, 64'd1, 0));
        send_item(mk(CMD_READ, 0, 0, 3, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 3, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 3, 15, 1, 1, 0, 0));
        send_item(mk(CMD_READ, 0, 1, 7, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 1, 7, 0, 0, 0, 0));
        send_item(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_QUERY, 0, 3, 9, 0, 0, 0, 0));
        for (int lv = 0; lv < 4; lv++)
            send_item(mk(CMD_PROGRESS, 0, 0, 3, 0, 0, 0, lv));
        send_item(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_bad_requests();
        set_regs(2, 4, 2);
        send_item(mk(CMD_APPEND, 5, 0, 1, 0, 0, 64'd7, 0));
        send_item(mk(CMD_APPEND, 1, 0, 9, 0, 0, 64'd7, 0));
        send_item(mk(CMD_APPEND, 1, 0, 9, 1, 1, 64'd8, 0));
        send_item(mk(CMD_READ, 0, 3, 0, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 9, 0, 0, 0, 0));
        send_item(mk(CMD_QUERY, 0, 2, 0, 0, 0, 0, 0));
        send_item(mk(CMD_PROGRESS, 0, 3, 0, 0, 0, 0, 1));
        send_item(mk(CMD_PROGRESS, 0, 0, 9, 0, 0, 0, 2));
        set_regs(0, 0, 0);
        send_item(mk(CMD_APPEND, 0, 0, 0, 0, 0, 64'd9, 0));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
        set_regs(15, 31, 7);
        for (int i = 0; i < 8; i++)
            send_item(mk(CMD_APPEND, i, 0, 2, 0, 0, {$urandom, $urandom}, 0));
        send_item(mk(CMD_READ, 0, 1, 2, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 1, 2, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 1, 2, 0, 0, 0, 0));
        // poll start now beyond a shrunk lane count
        set_regs(2, 16, 4);
        send_item(mk(CMD_READ, 0, 1, 2, 0, 0, 0, 0));
        set_regs(8, 16, 4);
    endtask

    task automatic test_backpressure();
        drain();
        hold_left = 300;
        no_idle = 1;
        for (int i = 0; i < 20; i++) send_item(rand_item());
        no_idle = 0;
        drain();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 690; i++) begin
            if (i % 150 == 149) begin
                case ($urandom_range(0, 2))
                    0: set_regs(8, 16, 4);
                    1: set_regs($urandom_range(1, 8), $urandom_range(1, 16),
                                $urandom_range(1, 4));
                    default: set_regs($urandom_range(0, 15), $urandom_range(0, 31),
                                      $urandom_range(0, 7));
                endcase
            end
            no_idle = (i % 100) < 15;
            send_item(rand_item());
        end
        no_idle = 0;
    endtask

    initial begin
        for (int i = 0; i < N_LANES; i++) head_seq[i] = 0;
        for (int i = 0; i < N_CONS*N_OWNERS*N_LANES; i++) next_seq[i] = 64'd1;
        for (int i = 0; i < N_CONS*N_OWNERS; i++) begin
            poll_lane[i] = 0;
            deliv_cnt[i] = 0;
            calc_mark[i] = 0;
            subm_mark[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_bad_requests();
        test_backpressure();
        test_random_mix();
        drain();
        repeat (50) @(posedge i_clk);
        $display("%0d transfers sent, %0d results checked, %0d appends refused as full",
                 n_sent, n_checked, n_full);
        $display("covered append/read/query/progress, bad requests, register extremes");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
hdl/mlco_pkg.sv
hdl/mlco_controller.sv
hdl/mlco_datapath.sv
hdl/multi_lane_cursor_outbox.sv
tb/tb_multi_lane_cursor_outbox.sv
